FILE: design/latent_factor_rating_predictor_assert.svh
// Assertion macros shared by the checker of the rating predictor.
`ifndef LATENT_FACTOR_RATING_PREDICTOR_ASSERT_SVH
`define LATENT_FACTOR_RATING_PREDICTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("lfr checker: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("lfr checker: next-cycle implication failed");

`endif

FILE: design/lfr_pkg.sv
// Shared types, field widths and codes of the latent-factor rating predictor.
package lfr_pkg;

	localparam int USERS_DEF        = 1024;
	localparam int MOVIES_DEF       = 1024;
	localparam int MAX_FEATURES_DEF = 64;

	localparam int OP_W      = 3;
	localparam int USER_W    = 10;
	localparam int MOVIE_W   = 10;
	localparam int FEAT_W    = 6;
	localparam int VALUE_W   = 16;
	localparam int RATING_W  = 15;
	localparam int GA_W      = 16;
	localparam int FIU_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	localparam int FRAC_BITS = 12;
	localparam int Q_ONE     = 4096;
	localparam int Q_FIVE    = 20480;

	localparam logic signed [GA_W-1:0] GA_RESET  = 16'sd14785;
	localparam logic [FIU_W-1:0]       FIU_RESET = 7'd50;

	// Must stay a power of two: queue pointers wrap by overflow.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [OP_W-1:0] OP_WR_USER_FEATURE  = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_MOVIE_FEATURE = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_USER_BIAS     = 3'd2;
	localparam logic [OP_W-1:0] OP_WR_MOVIE_BIAS    = 3'd3;
	localparam logic [OP_W-1:0] OP_PREDICT          = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_AVERAGE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURES_IN_USE = 1'b1;

	typedef enum logic [2:0] {
		CMD_USER_FEATURE  = 3'd0,
		CMD_MOVIE_FEATURE = 3'd1,
		CMD_USER_BIAS     = 3'd2,
		CMD_MOVIE_BIAS    = 3'd3,
		CMD_PREDICT       = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [USER_W-1:0]          user_index;
		logic [MOVIE_W-1:0]         movie_index;
		logic [FEAT_W-1:0]          feature_index;
		logic signed [VALUE_W-1:0]  value;
		logic                       user_ok;
		logic                       movie_ok;
	} cmd_t;

endpackage

FILE: design/lfr_front.sv
// Front end: accepts input items, decodes and range-checks them, and feeds the command queue.
module lfr_front #(
	parameter int USERS        = lfr_pkg::USERS_DEF,
	parameter int MOVIES       = lfr_pkg::MOVIES_DEF,
	parameter int MAX_FEATURES = lfr_pkg::MAX_FEATURES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lfr_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           q_push,
	output lfr_pkg::cmd_t                  q_push_cmd,
	input  logic                           q_full
);

	logic [lfr_pkg::OP_W-1:0]    op;
	logic [lfr_pkg::USER_W-1:0]  user_index;
	logic [lfr_pkg::MOVIE_W-1:0] movie_index;
	logic [lfr_pkg::FEAT_W-1:0]  feature_index;
	logic [lfr_pkg::VALUE_W-1:0] value;
	logic                        user_ok;
	logic                        movie_ok;
	logic                        feature_ok;
	logic                        keep;
	logic                        accept;
	lfr_pkg::cmd_t               dec;
	lfr_pkg::cmd_t               cmd_s1;
	logic                        vld_s1;

	assign op            = s_tdata[2:0];
	assign user_index    = s_tdata[12:3];
	assign movie_index   = s_tdata[22:13];
	assign feature_index = s_tdata[28:23];
	assign value         = s_tdata[44:29];

	assign user_ok    = 32'(user_index) < 32'(USERS);
	assign movie_ok   = 32'(movie_index) < 32'(MOVIES);
	assign feature_ok = 32'(feature_index) < 32'(MAX_FEATURES);

	// Writes that fall outside the tables and unused op codes are dropped here.
	always_comb begin
		dec.user_index    = user_index;
		dec.movie_index   = movie_index;
		dec.feature_index = feature_index;
		dec.value         = $signed(value);
		dec.user_ok       = user_ok;
		dec.movie_ok      = movie_ok;
		case (op)
			lfr_pkg::OP_WR_USER_FEATURE: begin
				dec.kind = lfr_pkg::CMD_USER_FEATURE;
				keep     = user_ok && feature_ok;
			end
			lfr_pkg::OP_WR_MOVIE_FEATURE: begin
				dec.kind = lfr_pkg::CMD_MOVIE_FEATURE;
				keep     = movie_ok && feature_ok;
			end
			lfr_pkg::OP_WR_USER_BIAS: begin
				dec.kind = lfr_pkg::CMD_USER_BIAS;
				keep     = user_ok;
			end
			lfr_pkg::OP_WR_MOVIE_BIAS: begin
				dec.kind = lfr_pkg::CMD_MOVIE_BIAS;
				keep     = movie_ok;
			end
			lfr_pkg::OP_PREDICT: begin
				dec.kind = lfr_pkg::CMD_PREDICT;
				keep     = 1'b1;
			end
			default: begin
				dec.kind = lfr_pkg::CMD_PREDICT;
				keep     = 1'b0;
			end
		endcase
	end

	assign q_push     = vld_s1 && !q_full;
	assign q_push_cmd = cmd_s1;
	assign s_tready   = !vld_s1 || !q_full;
	assign accept     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

FILE: design/lfr_queue.sv
// Short command queue between the front end and the execution back end.
module lfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lfr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output lfr_pkg::cmd_t pop_cmd,
	output logic          empty
);

	localparam int DEPTH = lfr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	lfr_pkg::cmd_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = count_q == (PTR_W+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: design/lfr_back.sv
// Back end: owns the four tables, carries out writes and runs the dot-product predict.
module lfr_back #(
	parameter int USERS        = lfr_pkg::USERS_DEF,
	parameter int MOVIES       = lfr_pkg::MOVIES_DEF,
	parameter int MAX_FEATURES = lfr_pkg::MAX_FEATURES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  lfr_pkg::cmd_t                        q_cmd,
	output logic                                 q_pop,
	input  logic signed [lfr_pkg::GA_W-1:0]      global_average,
	input  logic [lfr_pkg::FIU_W-1:0]            features_in_use,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [lfr_pkg::RATING_W-1:0]         rating
);

	localparam int UF_DEPTH = USERS * MAX_FEATURES;
	localparam int MF_DEPTH = MOVIES * MAX_FEATURES;
	localparam int UF_AW    = (UF_DEPTH > 1) ? $clog2(UF_DEPTH) : 1;
	localparam int MF_AW    = (MF_DEPTH > 1) ? $clog2(MF_DEPTH) : 1;
	localparam int UB_AW    = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int MB_AW    = (MOVIES > 1) ? $clog2(MOVIES) : 1;
	localparam int CNT_W    = $clog2(MAX_FEATURES + 1);
	localparam int VW       = lfr_pkg::VALUE_W;
	localparam int PROD_W   = 2 * VW;
	localparam int ACC_W    = PROD_W + CNT_W;
	localparam int SUM_W    = ACC_W - lfr_pkg::FRAC_BITS + 2;
	localparam int RW       = lfr_pkg::RATING_W;

	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(lfr_pkg::Q_ONE);
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(lfr_pkg::Q_FIVE);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_OUT   = 5'b10000
	} back_state_t;

	back_state_t state_q;

	logic signed [VW-1:0] uf_mem [UF_DEPTH];
	logic signed [VW-1:0] mf_mem [MF_DEPTH];
	logic signed [VW-1:0] ub_mem [USERS];
	logic signed [VW-1:0] mb_mem [MOVIES];

	logic                    start;
	logic                    wr_uf;
	logic                    wr_mf;
	logic                    wr_ub;
	logic                    wr_mb;
	logic [UF_AW-1:0]        uf_row;
	logic [MF_AW-1:0]        mf_row;
	logic [CNT_W-1:0]        n_sat;
	logic                    rd_issue;
	logic                    load_out;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        n_q;
	logic [UF_AW-1:0]        uf_base_q;
	logic [MF_AW-1:0]        mf_base_q;
	logic                    user_ok_q;
	logic                    movie_ok_q;
	logic                    rd_v_s1;
	logic signed [VW-1:0]    uf_rd_s1;
	logic signed [VW-1:0]    mf_rd_s1;
	logic                    mul_v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VW-1:0]    ub_rd_q;
	logic signed [VW-1:0]    mb_rd_q;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] total_q;
	logic [RW-1:0]           clipped;
	logic                    out_valid_q;
	logic [RW-1:0]           rating_q;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign start = q_pop && (q_cmd.kind == lfr_pkg::CMD_PREDICT);
	assign wr_uf = q_pop && (q_cmd.kind == lfr_pkg::CMD_USER_FEATURE);
	assign wr_mf = q_pop && (q_cmd.kind == lfr_pkg::CMD_MOVIE_FEATURE);
	assign wr_ub = q_pop && (q_cmd.kind == lfr_pkg::CMD_USER_BIAS);
	assign wr_mb = q_pop && (q_cmd.kind == lfr_pkg::CMD_MOVIE_BIAS);

	// Row start of a user or movie in the feature memories; the feature index is added on top.
	assign uf_row = UF_AW'(32'(q_cmd.user_index) * 32'(MAX_FEATURES));
	assign mf_row = MF_AW'(32'(q_cmd.movie_index) * 32'(MAX_FEATURES));

	assign n_sat = (32'(features_in_use) > 32'(MAX_FEATURES)) ?
		CNT_W'(MAX_FEATURES) : CNT_W'(features_in_use);

	assign rd_issue = (state_q == ST_RUN) && (cnt_q != n_q);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (wr_uf) begin
			uf_mem[uf_row + UF_AW'(q_cmd.feature_index)] <= q_cmd.value;
		end
		if (rd_issue) begin
			uf_rd_s1 <= uf_mem[uf_base_q + UF_AW'(cnt_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_mf) begin
			mf_mem[mf_row + MF_AW'(q_cmd.feature_index)] <= q_cmd.value;
		end
		if (rd_issue) begin
			mf_rd_s1 <= mf_mem[mf_base_q + MF_AW'(cnt_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ub) begin
			ub_mem[UB_AW'(q_cmd.user_index)] <= q_cmd.value;
		end
		if (start) begin
			ub_rd_q <= ub_mem[UB_AW'(q_cmd.user_index)];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_mb) begin
			mb_mem[MB_AW'(q_cmd.movie_index)] <= q_cmd.value;
		end
		if (start) begin
			mb_rd_q <= mb_mem[MB_AW'(q_cmd.movie_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= rd_issue;
			mul_v_s2 <= rd_v_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last product has reached the accumulator once both stages are empty.
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		sum = SUM_W'(global_average) + SUM_W'(acc_q >>> lfr_pkg::FRAC_BITS);
		if (user_ok_q) begin
			sum = sum + SUM_W'(ub_rd_q);
		end
		if (movie_ok_q) begin
			sum = sum + SUM_W'(mb_rd_q);
		end
	end

	always_comb begin
		if (total_q < SUM_LO) begin
			clipped = RW'(lfr_pkg::Q_ONE);
		end else if (total_q > SUM_HI) begin
			clipped = RW'(lfr_pkg::Q_FIVE);
		end else begin
			clipped = total_q[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q      <= '0;
			n_q        <= (q_cmd.user_ok && q_cmd.movie_ok) ? n_sat : '0;
			uf_base_q  <= uf_row;
			mf_base_q  <= mf_row;
			user_ok_q  <= q_cmd.user_ok;
			movie_ok_q <= q_cmd.movie_ok;
			acc_q      <= '0;
		end else begin
			if (rd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (mul_v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		prod_s2 <= uf_rd_s1 * mf_rd_s1;
		if (state_q == ST_SUM) begin
			total_q <= sum;
		end
		if (load_out) begin
			rating_q <= clipped;
		end
	end

	assign m_tvalid = out_valid_q;
	assign rating   = rating_q;

endmodule

FILE: design/latent_factor_rating_predictor.sv
// Top level of the latent-factor rating predictor: configuration registers and the three parts.
//
// Channel   Direction  Payload (lowest bit first)
// s_*       in         op[2:0] user_index[12:3] movie_index[22:13] feature_index[28:23]
//                      value[44:29], zeros above
// m_*       out        rating[14:0], zero in bit 15
// cfg_*     in         cfg_index 0 global_average, 1 features_in_use
//
// A write item is carried out as the back end pops it. A predict item streams one user/movie
// feature pair per cycle out of the two feature memories, up to min(features_in_use,
// MAX_FEATURES) pairs, and the back end takes no new item until it has loaded its result.
// The front end and a four-entry queue keep taking items while a predict runs, until the queue is full.
// Reset clears control state only; table entries are undefined until written.
// A stalled result holds in the output register and blocks only the back end.
module latent_factor_rating_predictor #(
	parameter int USERS        = lfr_pkg::USERS_DEF,
	parameter int MOVIES       = lfr_pkg::MOVIES_DEF,
	parameter int MAX_FEATURES = lfr_pkg::MAX_FEATURES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// op, user_index, movie_index, feature_index, value
	input  logic [lfr_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// rating
	output logic [lfr_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfr_pkg::CFG_W-1:0]      cfg_data
);

	logic signed [lfr_pkg::GA_W-1:0] ga_q;
	logic [lfr_pkg::FIU_W-1:0]       fiu_q;
	logic                            q_push;
	lfr_pkg::cmd_t                   q_push_cmd;
	logic                            q_full;
	logic                            q_pop;
	lfr_pkg::cmd_t                   q_pop_cmd;
	logic                            q_empty;
	logic [lfr_pkg::RATING_W-1:0]    rating;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q  <= lfr_pkg::GA_RESET;
			fiu_q <= lfr_pkg::FIU_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lfr_pkg::REG_GLOBAL_AVERAGE: begin
					ga_q <= $signed(cfg_data[lfr_pkg::GA_W-1:0]);
				end
				lfr_pkg::REG_FEATURES_IN_USE: begin
					fiu_q <= cfg_data[lfr_pkg::FIU_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	lfr_front #(
		.USERS        (USERS),
		.MOVIES       (MOVIES),
		.MAX_FEATURES (MAX_FEATURES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_push     (q_push),
		.q_push_cmd (q_push_cmd),
		.q_full     (q_full)
	);

	lfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.empty    (q_empty)
	);

	lfr_back #(
		.USERS        (USERS),
		.MOVIES       (MOVIES),
		.MAX_FEATURES (MAX_FEATURES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_cmd           (q_pop_cmd),
		.q_pop           (q_pop),
		.global_average  (ga_q),
		.features_in_use (fiu_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.rating          (rating)
	);

	assign m_tdata = {{(lfr_pkg::M_TDATA_W - lfr_pkg::RATING_W){1'b0}}, rating};

endmodule

FILE: design/lfr_checker.sv
// Port-level checker for the rating predictor and its bind to the top level.
`include "latent_factor_rating_predictor_assert.svh"

module lfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lfr_pkg::M_TDATA_W-1:0]  m_tdata
);

	// A result that is not taken stays put.
	`LFR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Every rating lies in the clipped range 1.0 to 5.0 and the pad bit is zero.
	`LFR_ASSERT_IMPLIES(a_out_range, clk, arst_n, m_tvalid, (m_tdata >= 16'(lfr_pkg::Q_ONE)) && (m_tdata <= 16'(lfr_pkg::Q_FIVE)))

	// Coming out of reset the block is empty: input open, no result pending.
	`LFR_ASSERT_IMPLIES(a_reset_empty, clk, arst_n, !$past(arst_n), s_tready && !m_tvalid)

endmodule

bind latent_factor_rating_predictor lfr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
